// ===== src/ansi_escape_code_splitter_core_macros.svh =====
// Assertion helpers for the escape code splitter.
// Each macro expands to one labeled concurrent assertion that is disabled
// while the asynchronous reset is asserted.
`ifndef ANSI_ESCAPE_CODE_SPLITTER_CORE_MACROS_SVH
`define ANSI_ESCAPE_CODE_SPLITTER_CORE_MACROS_SVH

// Check a condition at every rising clock edge.
`define AECS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define AECS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its trigger.
`define AECS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/aecs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aecs_pkg
// Shared types and constants of the escape code splitter.
// ----------------------------------------------------------------------------
package aecs_pkg;

	localparam int CODE_BUFFER_SIZE_DEFAULT = 32;

	localparam int BYTE_W   = 8;
	localparam int INDEX_W  = 6;
	localparam int LENGTH_W = 7;

	// Byte values and class boundaries
	localparam logic [BYTE_W-1:0] BYTE_NUL       = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_ESC       = 8'h1B;
	localparam logic [BYTE_W-1:0] BYTE_CSI_OPEN  = 8'h5B;
	localparam logic [BYTE_W-1:0] BYTE_INTER_LO  = 8'h20;
	localparam logic [BYTE_W-1:0] BYTE_INTER_HI  = 8'h2F;
	localparam logic [BYTE_W-1:0] BYTE_PARAM_LO  = 8'h30;
	localparam logic [BYTE_W-1:0] BYTE_PARAM_HI  = 8'h3F;
	localparam logic [BYTE_W-1:0] BYTE_CSI_FINAL = 8'h40;
	localparam logic [BYTE_W-1:0] BYTE_PRINT_HI  = 8'h7E;

	typedef enum logic [1:0] {
		CLASS_PLAIN = 2'd0,
		CLASS_ESC   = 2'd1,
		CLASS_CSI   = 2'd2
	} code_class_t;

	typedef struct packed {
		logic byte_take;  // input word accepted this cycle
		logic beat_take;  // output word taken this cycle
	} aecs_cmd_t;

	typedef struct packed {
		logic code_done;  // accepted byte closes a code
		logic last_beat;  // read pointer sits on the final byte
	} aecs_status_t;

endpackage

// ===== src/aecs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aecs_in_if
// Byte stream channel into the splitter.
// ----------------------------------------------------------------------------
interface aecs_in_if import aecs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink   (input valid, input byte_in, output ready);
endinterface

// ===== src/aecs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aecs_out_if
// Channel of code bytes out of the splitter.
// ----------------------------------------------------------------------------
interface aecs_out_if import aecs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   code_byte;
	logic [INDEX_W-1:0]  byte_index;
	logic [LENGTH_W-1:0] code_len;
	code_class_t         code_class;
	logic                last;

	modport source (output valid, output code_byte, output byte_index,
		output code_len, output code_class, output last, input ready);
	modport sink   (input valid, input code_byte, input byte_index,
		input code_len, input code_class, input last, output ready);
endinterface

// ===== src/aecs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aecs_datapath
// Byte classifier, parse mode, code buffer and read-out pointer.
// ----------------------------------------------------------------------------
`include "ansi_escape_code_splitter_core_macros.svh"

module aecs_datapath import aecs_pkg::*; #(
	parameter int CODE_BUFFER_SIZE = CODE_BUFFER_SIZE_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  aecs_cmd_t           cmd,
	input  logic [BYTE_W-1:0]   byte_in,
	output aecs_status_t        status,
	output logic [BYTE_W-1:0]   code_byte,
	output logic [INDEX_W-1:0]  byte_index,
	output logic [LENGTH_W-1:0] code_len,
	output code_class_t         code_class
);

	localparam int CW = $clog2(CODE_BUFFER_SIZE);
	localparam logic [CW-1:0] ROOM_LIM = CW'(CODE_BUFFER_SIZE - 1);
	localparam logic [CW-1:0] ONE      = CW'(1);

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_ESC,
		MODE_CSI_PARAM,
		MODE_CSI_INTER
	} parse_mode_t;

	parse_mode_t       mode_q, mode_d;
	logic [CW-1:0]     count_q, count_d;
	code_class_t       cls_q, cls_d;
	logic [CW-1:0]     rd_ptr_q, rd_ptr_d;
	logic [BYTE_W-1:0] rd_data_q;
	logic [BYTE_W-1:0] mem [CODE_BUFFER_SIZE];

	logic          wr_en;
	logic [CW-1:0] wr_addr;
	logic          done;
	logic          room;
	logic          is_nul, is_esc, is_open, is_print, is_high;
	logic          is_inter, is_param, is_final;

	always_comb begin
		is_nul   = (byte_in == BYTE_NUL);
		is_esc   = (byte_in == BYTE_ESC);
		is_open  = (byte_in == BYTE_CSI_OPEN);
		is_print = byte_in inside {[BYTE_INTER_LO:BYTE_PRINT_HI]};
		is_high  = (byte_in >= BYTE_PARAM_LO);
		is_inter = byte_in inside {[BYTE_INTER_LO:BYTE_INTER_HI]};
		is_param = byte_in inside {[BYTE_PARAM_LO:BYTE_PARAM_HI]};
		is_final = byte_in inside {[BYTE_CSI_FINAL:BYTE_PRINT_HI]};
		room     = (count_q < ROOM_LIM);
	end

	// Parse one accepted byte
	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		cls_d   = cls_q;
		wr_en   = 1'b0;
		wr_addr = count_q;
		done    = 1'b0;
		if (cmd.byte_take && !is_nul) begin
			if (is_esc) begin
				wr_en   = 1'b1;
				wr_addr = '0;
				count_d = ONE;
				mode_d  = MODE_ESC;
				cls_d   = CLASS_ESC;
			end else begin
				case (mode_q)
					MODE_ESC: begin
						if (is_open && count_q == ONE) begin
							wr_en   = 1'b1;
							count_d = count_q + ONE;
							mode_d  = MODE_CSI_PARAM;
							cls_d   = CLASS_CSI;
						end else if (is_print && room) begin
							wr_en   = 1'b1;
							count_d = count_q + ONE;
							if (is_high) begin
								done   = 1'b1;
								mode_d = MODE_NONE;
							end
						end else begin
							// full buffer or control byte: flush and drop it
							done   = 1'b1;
							mode_d = MODE_NONE;
						end
					end
					MODE_CSI_PARAM, MODE_CSI_INTER: begin
						if (is_param) begin
							if (mode_q == MODE_CSI_PARAM && room) begin
								wr_en   = 1'b1;
								count_d = count_q + ONE;
							end else begin
								done   = 1'b1;
								mode_d = MODE_NONE;
							end
						end else if (is_inter) begin
							mode_d = MODE_CSI_INTER;
							if (room) begin
								wr_en   = 1'b1;
								count_d = count_q + ONE;
							end else begin
								done   = 1'b1;
								mode_d = MODE_NONE;
							end
						end else if (is_final) begin
							// a final byte is dropped when the buffer is full
							wr_en   = room;
							count_d = room ? count_q + ONE : count_q;
							done    = 1'b1;
							mode_d  = MODE_NONE;
						end else begin
							done   = 1'b1;
							mode_d = MODE_NONE;
						end
					end
					default: begin
						wr_en   = 1'b1;
						wr_addr = '0;
						count_d = ONE;
						cls_d   = CLASS_PLAIN;
						done    = 1'b1;
					end
				endcase
			end
		end
	end

	always_comb begin
		status.code_done = done;
		status.last_beat = (rd_ptr_q == count_q - ONE);
		rd_ptr_d = rd_ptr_q;
		if (cmd.beat_take) begin
			rd_ptr_d = status.last_beat ? '0 : rd_ptr_q + ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NONE;
			count_q  <= '0;
			cls_q    <= CLASS_PLAIN;
			rd_ptr_q <= '0;
		end else begin
			mode_q   <= mode_d;
			count_q  <= count_d;
			cls_q    <= cls_d;
			rd_ptr_q <= rd_ptr_d;
		end
	end

	// Code buffer: one write port, one registered read port with write bypass
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= byte_in;
		end
		rd_data_q <= (wr_en && wr_addr == rd_ptr_d) ? byte_in : mem[rd_ptr_d];
	end

	assign code_byte  = rd_data_q;
	assign byte_index = INDEX_W'(rd_ptr_q);
	assign code_len   = LENGTH_W'(count_q);
	assign code_class = cls_q;

	`AECS_ASSERT_ALWAYS(a_count_in_range, clk, arst_n, count_q <= ROOM_LIM,
		"code count overflow")
	`AECS_ASSERT_NOW(a_ptr_inside_code, clk, arst_n, rd_ptr_q != '0,
		rd_ptr_q < count_q, "read pointer past code end")
	`AECS_ASSERT_NEXT(a_nul_keeps_state, clk, arst_n, cmd.byte_take && is_nul,
		$stable(count_q) && $stable(mode_q), "NUL byte changed parse state")

endmodule

// ===== src/aecs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aecs_ctrl
// Sequencer: collect bytes, then read a finished code out word by word.
// ----------------------------------------------------------------------------
`include "ansi_escape_code_splitter_core_macros.svh"

module aecs_ctrl import aecs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         out_ready,
	input  aecs_status_t status,
	output logic         in_ready,
	output logic         out_valid,
	output aecs_cmd_t    cmd
);

	typedef enum logic {
		ST_COLLECT,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_comb begin
		out_valid     = (state_q == ST_EMIT);
		// take the next word alongside the last word of a code
		in_ready      = (state_q == ST_COLLECT) || (out_valid && out_ready && status.last_beat);
		cmd.byte_take = in_valid && in_ready;
		cmd.beat_take = out_valid && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			case (state_q)
				ST_COLLECT: begin
					if (cmd.byte_take && status.code_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.byte_take && status.code_done) begin
						state_q <= ST_EMIT;
					end else if (cmd.beat_take && status.last_beat) begin
						state_q <= ST_COLLECT;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	`AECS_ASSERT_NEXT(a_done_enters_emit, clk, arst_n, cmd.byte_take && status.code_done,
		state_q == ST_EMIT, "finished code not read out")
	`AECS_ASSERT_NEXT(a_last_returns, clk, arst_n,
		cmd.beat_take && status.last_beat && !(cmd.byte_take && status.code_done),
		state_q == ST_COLLECT, "read-out did not end on last word")
	`AECS_ASSERT_NOW(a_emit_holds_input, clk, arst_n,
		state_q == ST_EMIT && !(out_ready && status.last_beat),
		!in_ready, "input taken in the middle of a read-out")

endmodule

// ===== src/ansi_escape_code_splitter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_escape_code_splitter_core
// Splits a terminal byte stream into plain bytes, ESC codes and ESC [ codes.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while a code is being collected; NUL bytes
// are taken and dropped. When a byte closes a code, the code is read out of
// the code buffer one word per cycle while the output is ready, through its
// registered read port, and input is stalled during the read-out except in
// the cycle in which the last word is taken, where the next byte is accepted
// alongside it. A stream of plain bytes therefore runs at one byte per cycle
// while the output is ready; an escape code holds the output busy for one
// word per code byte after its closing byte. Every result word carries the
// code byte, its position, the code length, the code class and a last flag.
// No clearing pass is needed after reset.
module ansi_escape_code_splitter_core import aecs_pkg::*; #(
	parameter int CODE_BUFFER_SIZE = CODE_BUFFER_SIZE_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	aecs_in_if.sink    rx,
	aecs_out_if.source tx
);

	aecs_cmd_t    cmd;
	aecs_status_t status;
	logic         in_ready;
	logic         out_valid;

	aecs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.out_ready (tx.ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	aecs_datapath #(
		.CODE_BUFFER_SIZE (CODE_BUFFER_SIZE)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.byte_in    (rx.byte_in),
		.status     (status),
		.code_byte  (tx.code_byte),
		.byte_index (tx.byte_index),
		.code_len   (tx.code_len),
		.code_class (tx.code_class)
	);

	assign rx.ready = in_ready;
	assign tx.valid = out_valid;
	assign tx.last  = status.last_beat;

endmodule

// ===== tb/ansi_escape_code_splitter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_escape_code_splitter_core_tb
// Self-checking bench for the escape code splitter.
// ----------------------------------------------------------------------------
// A short scripted byte stream covers plain bytes, ESC and ESC [ codes, NUL
// drops, abandoned codes, invalid bytes and buffer overflow. Random code
// streams follow under three idling patterns, one with a long output stall.
// Every code word is checked against a cycle-free model of the splitter or against a word typed into the script.
module ansi_escape_code_splitter_core_tb;
	import aecs_pkg::*;

	localparam int BUF_SIZE   = CODE_BUFFER_SIZE_DEFAULT;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;

	typedef enum logic [1:0] {
		SCAN_TEXT,
		SCAN_ESC,
		SCAN_CSI_PARAM,
		SCAN_CSI_INTER
	} scan_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   code_byte;
		logic [INDEX_W-1:0]  byte_index;
		logic [LENGTH_W-1:0] code_len;
		code_class_t         code_class;
		logic                last;
	} code_word_t;

	typedef struct {
		logic [BYTE_W-1:0] b;
		int                reps;
		bit                typed;
		code_word_t        word;
	} script_row_t;

	logic clk;
	logic arst_n;

	aecs_in_if  rx_if ();
	aecs_out_if tx_if ();

	ansi_escape_code_splitter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	// Model state
	scan_state_t       scan_state;
	logic [BYTE_W-1:0] held_code [BUF_SIZE];
	int                held_count;
	code_word_t        fresh_words [$];
	code_word_t        awaited_words [$];

	int errors;
	int sent_items;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_armed;
	int hold_done;
	int stall_cycles;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic bit hold_byte(input logic [BYTE_W-1:0] b);
		if (held_count < BUF_SIZE - 1) begin
			held_code[held_count] = b;
			held_count++;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the model by one accepted byte; fresh_words gets the code it closes.
	task automatic split_byte(input logic [BYTE_W-1:0] b);
		bit          done;
		code_class_t cls;
		code_word_t  w;
		done = 1'b0;
		fresh_words.delete();
		if (b == BYTE_NUL)
			return;
		if (b == BYTE_ESC) begin
			scan_state = SCAN_ESC;
			held_code[0] = b;
			held_count = 1;
		end else begin
			case (scan_state)
				SCAN_ESC: begin
					if (b == BYTE_CSI_OPEN && held_count == 1) begin
						void'(hold_byte(b));
						scan_state = SCAN_CSI_PARAM;
					end else if (b >= BYTE_INTER_LO && b <= BYTE_PRINT_HI) begin
						if (hold_byte(b)) begin
							if (b >= BYTE_PARAM_LO)
								done = 1'b1;
						end else begin
							done = 1'b1;
						end
					end else begin
						done = 1'b1;
					end
				end
				SCAN_CSI_PARAM, SCAN_CSI_INTER: begin
					if (b >= BYTE_PARAM_LO && b <= BYTE_PARAM_HI) begin
						if (scan_state != SCAN_CSI_PARAM || !hold_byte(b))
							done = 1'b1;
					end else if (b >= BYTE_INTER_LO && b <= BYTE_INTER_HI) begin
						scan_state = SCAN_CSI_INTER;
						if (!hold_byte(b))
							done = 1'b1;
					end else if (b >= BYTE_CSI_FINAL && b <= BYTE_PRINT_HI) begin
						void'(hold_byte(b));
						done = 1'b1;
					end else begin
						done = 1'b1;
					end
				end
				default: begin
					held_code[0] = b;
					held_count = 1;
					done = 1'b1;
				end
			endcase
		end
		if (!done || held_count == 0)
			return;
		scan_state = SCAN_TEXT;
		if (held_count >= 2 && held_code[0] == BYTE_ESC && held_code[1] == BYTE_CSI_OPEN)
			cls = CLASS_CSI;
		else if (held_code[0] == BYTE_ESC)
			cls = CLASS_ESC;
		else
			cls = CLASS_PLAIN;
		for (int k = 0; k < held_count; k++) begin
			w.code_byte  = held_code[k];
			w.byte_index = k[INDEX_W-1:0];
			w.code_len   = held_count[LENGTH_W-1:0];
			w.code_class = cls;
			w.last       = (k + 1 == held_count);
			fresh_words.push_back(w);
		end
	endtask

	// Offer one byte, wait for it to be taken, then log what it should produce.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
		input code_word_t word);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.byte_in <= b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		split_byte(b);
		if (typed)
			awaited_words.push_back(word);
		else
			foreach (fresh_words[i])
				awaited_words.push_back(fresh_words[i]);
		if (b != BYTE_NUL)
			sent_items++;
	endtask

	task automatic feed_byte(input logic [BYTE_W-1:0] b);
		if ($urandom_range(99) < 4)
			send_byte(BYTE_NUL, 1'b0, '0);
		send_byte(b, 1'b0, '0);
	endtask

	task automatic feed_random_codes(input int n_items);
		int goal;
		int kind;
		goal = sent_items + n_items;
		while (sent_items < goal) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				feed_byte(BYTE_W'($urandom_range(1, 255)));
			end else if (kind < 60) begin
				feed_byte(BYTE_ESC);
				repeat ($urandom_range(0, 2))
					feed_byte(BYTE_W'($urandom_range(BYTE_INTER_LO, BYTE_INTER_HI)));
				feed_byte(BYTE_W'($urandom_range(BYTE_PARAM_LO, BYTE_PRINT_HI)));
			end else if (kind < 85) begin
				feed_byte(BYTE_ESC);
				feed_byte(BYTE_CSI_OPEN);
				repeat ($urandom_range(0, 5))
					feed_byte(BYTE_W'($urandom_range(BYTE_PARAM_LO, BYTE_PARAM_HI)));
				repeat ($urandom_range(0, 2))
					feed_byte(BYTE_W'($urandom_range(BYTE_INTER_LO, BYTE_INTER_HI)));
				feed_byte(BYTE_W'($urandom_range(BYTE_CSI_FINAL, BYTE_PRINT_HI)));
			end else if (kind < 88) begin
				// run up to or past the buffer end
				feed_byte(BYTE_ESC);
				feed_byte(BYTE_CSI_OPEN);
				repeat ($urandom_range(26, 33))
					feed_byte(BYTE_W'($urandom_range(BYTE_PARAM_LO, BYTE_PARAM_HI)));
				feed_byte(BYTE_W'($urandom_range(BYTE_CSI_FINAL, BYTE_PRINT_HI)));
			end else if (kind < 90) begin
				feed_byte(BYTE_ESC);
				repeat ($urandom_range(28, 32))
					feed_byte(BYTE_W'($urandom_range(BYTE_INTER_LO, BYTE_INTER_HI)));
				feed_byte(BYTE_W'($urandom_range(BYTE_PARAM_LO, BYTE_PRINT_HI)));
			end else if (kind < 95) begin
				repeat ($urandom_range(1, 4))
					feed_byte(BYTE_W'($urandom_range(0, 255)));
			end else begin
				feed_byte(BYTE_ESC);
				if ($urandom_range(1)) begin
					feed_byte(BYTE_CSI_OPEN);
					feed_byte(BYTE_W'($urandom_range(BYTE_PARAM_LO, BYTE_PARAM_HI)));
				end
				feed_byte(BYTE_W'($urandom_range(0, 255)));
			end
		end
	endtask

	// Output receiver: random stalls, plus one long hold-off once armed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_if.ready <= 1'b0;
		end else if (hold_armed && hold_done < HOLD_CYCLES) begin
			tx_if.ready <= 1'b0;
			hold_done <= hold_done + 1;
		end else begin
			tx_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Code word checker
	always @(posedge clk) begin
		code_word_t got;
		code_word_t want;
		if (arst_n && tx_if.valid && tx_if.ready) begin
			got.code_byte  = tx_if.code_byte;
			got.byte_index = tx_if.byte_index;
			got.code_len   = tx_if.code_len;
			got.code_class = tx_if.code_class;
			got.last       = tx_if.last;
			if (awaited_words.size() == 0) begin
				$display("%0t: unexpected word: byte %h index %0d length %0d class %0d last %b",
					$time, got.code_byte, got.byte_index, got.code_len,
					got.code_class, got.last);
				errors++;
			end else begin
				want = awaited_words.pop_front();
				if (got.code_byte !== want.code_byte || got.byte_index !== want.byte_index ||
					got.code_len !== want.code_len ||
					got.code_class !== want.code_class || got.last !== want.last) begin
					$display("%0t: mismatch: expected byte %h index %0d length %0d class %0d last %b",
						$time, want.code_byte, want.byte_index, want.code_len,
						want.code_class, want.last);
					$display("%0t:           actual byte %h index %0d length %0d class %0d last %b",
						$time, got.code_byte, got.byte_index, got.code_len,
						got.code_class, got.last);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, stall_cycles);
				$display("ansi_escape_code_splitter_core test failed");
				$finish;
			end
		end
	end

	initial begin
		script_row_t script [$];
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.byte_in = '0;
		tx_if.ready   = 1'b0;
		errors        = 0;
		sent_items    = 0;
		hold_armed    = 1'b0;
		hold_done     = 0;
		stall_cycles  = 0;
		scan_state    = SCAN_TEXT;
		held_count    = 0;
		send_idle_pct = 13;
		recv_idle_pct = 73;

		// plain bytes straight after reset
		script.push_back('{8'h41, 1, 1'b1, '{8'h41, 6'd0, 7'd1, CLASS_PLAIN, 1'b1}});
		script.push_back('{8'hFF, 1, 1'b1, '{8'hFF, 6'd0, 7'd1, CLASS_PLAIN, 1'b1}});
		script.push_back('{8'h01, 1, 1'b1, '{8'h01, 6'd0, 7'd1, CLASS_PLAIN, 1'b1}});
		// control character after ESC closes a one-byte code
		script.push_back('{BYTE_ESC, 1, 1'b0, '0});
		script.push_back('{8'h07, 1, 1'b1, '{BYTE_ESC, 6'd0, 7'd1, CLASS_ESC, 1'b1}});
		// ESC ( B
		script.push_back('{BYTE_ESC, 1, 1'b0, '0});
		script.push_back('{8'h28, 1, 1'b0, '0});
		script.push_back('{8'h42, 1, 1'b0, '0});
		// ESC [ 1 m with a NUL dropped inside
		script.push_back('{BYTE_ESC, 1, 1'b0, '0});
		script.push_back('{BYTE_CSI_OPEN, 1, 1'b0, '0});
		script.push_back('{8'h31, 1, 1'b0, '0});
		script.push_back('{BYTE_NUL, 1, 1'b0, '0});
		script.push_back('{8'h6D, 1, 1'b0, '0});
		// parameter after an intermediate is invalid
		script.push_back('{BYTE_ESC, 1, 1'b0, '0});
		script.push_back('{BYTE_CSI_OPEN, 1, 1'b0, '0});
		script.push_back('{8'h20, 1, 1'b0, '0});
		script.push_back('{8'h31, 1, 1'b0, '0});
		// ESC abandons an open code
		script.push_back('{BYTE_ESC, 1, 1'b0, '0});
		script.push_back('{8'h21, 1, 1'b0, '0});
		script.push_back('{BYTE_ESC, 1, 1'b0, '0});
		script.push_back('{BYTE_CSI_OPEN, 1, 1'b0, '0});
		script.push_back('{BYTE_PRINT_HI, 1, 1'b0, '0});
		// '[' away from the ESC is a final byte
		script.push_back('{BYTE_ESC, 1, 1'b0, '0});
		script.push_back('{8'h21, 1, 1'b0, '0});
		script.push_back('{BYTE_CSI_OPEN, 1, 1'b0, '0});
		// DEL after ESC is invalid
		script.push_back('{BYTE_ESC, 1, 1'b0, '0});
		script.push_back('{8'h7F, 1, 1'b1, '{BYTE_ESC, 6'd0, 7'd1, CLASS_ESC, 1'b1}});
		// overflow: final byte is dropped, held bytes go out truncated
		script.push_back('{BYTE_ESC, 1, 1'b0, '0});
		script.push_back('{BYTE_CSI_OPEN, 1, 1'b0, '0});
		script.push_back('{BYTE_PARAM_LO, BUF_SIZE - 3, 1'b0, '0});
		script.push_back('{8'h6D, 1, 1'b0, '0});
		script.push_back('{BYTE_ESC, 1, 1'b0, '0});
		script.push_back('{BYTE_INTER_LO, BUF_SIZE - 2, 1'b0, '0});
		script.push_back('{8'h41, 1, 1'b0, '0});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			repeat (script[i].reps)
				send_byte(script[i].b, script[i].typed, script[i].word);

		feed_random_codes(45);
		send_idle_pct = 73;
		recv_idle_pct = 13;
		feed_random_codes(45);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_armed    = 1'b1;
		feed_random_codes(35);
		rx_if.valid <= 1'b0;

		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (errors == 0)
			$display("ansi_escape_code_splitter_core test passed");
		else
			$display("ansi_escape_code_splitter_core test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/aecs_pkg.sv
src/aecs_in_if.sv
src/aecs_out_if.sv
src/aecs_datapath.sv
src/aecs_ctrl.sv
src/ansi_escape_code_splitter_core.sv
tb/ansi_escape_code_splitter_core_tb.sv
